// ----- sv/fbpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int ADDR_W      = 32;
  localparam int CNT_REG_W   = 11;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int TDATA_W     = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CNT_REG_W-1:0] UNIT_COUNT_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 1'b0,
    CFG_UNIT_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_MUL,
    S_FREE_WAIT,
    S_FREE_CHK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic done;
    logic ok;
  } dec_stat_t;

endpackage

// ----- sv/fixed_block_pool_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool allocator with a LIFO free list in block RAM.
// Init and unused opcodes go straight to the result register. Alloc reads the
//   free-list link, pops the head and multiplies out the address. Free runs
//   the four-stage address decoder, reads the mark and writes the link back.
//   A new operation is accepted only once the last result is registered.
// Reset: asynchronous, pool empty of allocations, base 0, unit count 1024.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int MAX_UNITS  = 1024,
  parameter int UNIT_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // opcode[1:0], address[33:2]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // status[1:0], unit_address[33:2]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_UNITS);
  localparam int CNT_W = $clog2(MAX_UNITS + 1);

  logic [ADDR_W-1:0]    pool_base_q;
  logic [CNT_REG_W-1:0] unit_count_q;
  logic [CNT_W-1:0]     limit;
  dec_stat_t            dec_stat;
  logic [IDX_W-1:0]     dec_idx;
  logic                 dec_start;
  logic                 link_we, mark_we, mark_wdata;
  logic [IDX_W-1:0]     link_waddr, link_wdata, link_raddr, link_rdata;
  logic [IDX_W-1:0]     mark_waddr, mark_raddr;
  logic                 mark_rdata;
  logic [ST_W-1:0]      out_status;
  logic [ADDR_W-1:0]    out_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      unit_count_q <= UNIT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_POOL_BASE:  pool_base_q  <= cfg_data_i;
        CFG_UNIT_COUNT: unit_count_q <= cfg_data_i[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = (32'(unit_count_q) > 32'(MAX_UNITS)) ? CNT_W'(MAX_UNITS)
                                                      : CNT_W'(unit_count_q);

  fbpa_addr_dec #(
    .MAX_UNITS (MAX_UNITS),
    .UNIT_BYTES(UNIT_BYTES)
  ) u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dec_start),
    .addr_i     (s_axis_tdata[OP_W +: ADDR_W]),
    .pool_base_i(pool_base_q),
    .limit_i    (limit),
    .stat_o     (dec_stat),
    .idx_o      (dec_idx)
  );

  fbpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_UNITS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  fbpa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_UNITS)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (mark_we),
    .waddr_i(mark_waddr),
    .wdata_i(mark_wdata),
    .raddr_i(mark_raddr),
    .rdata_o(mark_rdata)
  );

  fbpa_ctrl #(
    .MAX_UNITS (MAX_UNITS),
    .UNIT_BYTES(UNIT_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tdata[OP_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(out_status),
    .out_addr_o  (out_addr),
    .pool_base_i (pool_base_q),
    .limit_i     (limit),
    .dec_start_o (dec_start),
    .dec_i       (dec_stat),
    .dec_idx_i   (dec_idx),
    .link_we_o   (link_we),
    .link_waddr_o(link_waddr),
    .link_wdata_o(link_wdata),
    .link_raddr_o(link_raddr),
    .link_rdata_i(link_rdata),
    .mark_we_o   (mark_we),
    .mark_waddr_o(mark_waddr),
    .mark_wdata_o(mark_wdata),
    .mark_raddr_o(mark_raddr),
    .mark_rdata_i(mark_rdata)
  );

  assign m_axis_tdata = {(TDATA_W - ADDR_W - ST_W)'(0), out_addr, out_status};

endmodule

// ----- sv/fbpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fbpa_addr_dec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_addr_dec
// Free address decoder: offset from base, range check, reciprocal multiply
// for the unit index and exact-multiple check, four pipeline stages.
// ----------------------------------------------------------------------------
module fbpa_addr_dec
  import fbpa_pkg::*;
#(
  parameter int MAX_UNITS  = 1024,
  parameter int UNIT_BYTES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ADDR_W-1:0]                addr_i,
  input  logic [ADDR_W-1:0]                pool_base_i,
  input  logic [$clog2(MAX_UNITS+1)-1:0]   limit_i,
  output dec_stat_t                        stat_o,
  output logic [$clog2(MAX_UNITS)-1:0]     idx_o
);

  localparam int IDX_W  = $clog2(MAX_UNITS);
  localparam int CNT_W  = $clog2(MAX_UNITS + 1);
  localparam int OFF_W  = $clog2(MAX_UNITS * UNIT_BYTES);
  localparam int LB_W   = OFF_W + 1;
  localparam int LOG_UB = $clog2(UNIT_BYTES);
  localparam int SHIFT  = OFF_W + LOG_UB;
  localparam int RCP_W  = OFF_W + 2;
  localparam int PROD_W = OFF_W + RCP_W;
  localparam longint unsigned RCP_VAL = ((64'd1 << SHIFT) / UNIT_BYTES) + 64'd1;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_VAL);
  localparam logic [OFF_W-1:0] UB_K  = OFF_W'(UNIT_BYTES);

  logic [3:0]        v_q;
  logic [ADDR_W:0]   diff;
  logic [ADDR_W-1:0] off_q;
  logic              below_q;
  logic [LB_W-1:0]   lim_bytes_q;
  logic              rng_q;
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  idx_q;
  logic [OFF_W-1:0]  back_q;

  assign diff = {1'b0, addr_i} - {1'b0, pool_base_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lim_bytes_q <= LB_W'(32'(limit_i) * 32'(UNIT_BYTES));
    if (start_i) begin
      off_q   <= diff[ADDR_W-1:0];
      below_q <= diff[ADDR_W];
    end
    if (v_q[0]) begin
      rng_q  <= !below_q && (off_q < ADDR_W'(lim_bytes_q));
      prod_q <= PROD_W'(PROD_W'(off_q[OFF_W-1:0]) * PROD_W'(RECIP));
    end
    if (v_q[1]) begin
      idx_q <= IDX_W'(prod_q >> SHIFT);
    end
    if (v_q[2]) begin
      back_q <= OFF_W'(OFF_W'(idx_q) * UB_K);
    end
  end

  assign stat_o.done = v_q[3];
  assign stat_o.ok   = rng_q && (back_q == off_q[OFF_W-1:0]);
  assign idx_o       = idx_q;

endmodule

// ----- sv/fbpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer of the allocator: free-list head, fresh counter, link and mark
// memory accesses, result register.
// ----------------------------------------------------------------------------
module fbpa_ctrl
  import fbpa_pkg::*;
#(
  parameter int MAX_UNITS  = 1024,
  parameter int UNIT_BYTES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [OP_W-1:0]                in_op_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ST_W-1:0]                out_status_o,
  output logic [ADDR_W-1:0]              out_addr_o,
  input  logic [ADDR_W-1:0]              pool_base_i,
  input  logic [$clog2(MAX_UNITS+1)-1:0] limit_i,
  output logic                           dec_start_o,
  input  dec_stat_t                      dec_i,
  input  logic [$clog2(MAX_UNITS)-1:0]   dec_idx_i,
  output logic                           link_we_o,
  output logic [$clog2(MAX_UNITS)-1:0]   link_waddr_o,
  output logic [$clog2(MAX_UNITS)-1:0]   link_wdata_o,
  output logic [$clog2(MAX_UNITS)-1:0]   link_raddr_o,
  input  logic [$clog2(MAX_UNITS)-1:0]   link_rdata_i,
  output logic                           mark_we_o,
  output logic [$clog2(MAX_UNITS)-1:0]   mark_waddr_o,
  output logic                           mark_wdata_o,
  output logic [$clog2(MAX_UNITS)-1:0]   mark_raddr_o,
  input  logic                           mark_rdata_i
);

  localparam int IDX_W = $clog2(MAX_UNITS);
  localparam int CNT_W = $clog2(MAX_UNITS + 1);

  ctrl_state_e       state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              nonempty_q, nonempty_d;
  logic [CNT_W-1:0]  fresh_q, fresh_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              has_addr_q, has_addr_d;
  status_e           st_q, st_d;
  logic [ADDR_W-1:0] mul_q, mul_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_st_q, out_st_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic              accept;
  logic              out_free;
  op_e               op;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign op       = op_e'(in_op_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_ALLOC: state_d = S_ALLOC;
            OP_FREE:  state_d = S_FREE_WAIT;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_ALLOC: state_d = S_MUL;
      S_MUL:   state_d = S_DONE;
      S_FREE_WAIT: begin
        if (dec_i.done) begin
          state_d = dec_i.ok ? S_FREE_CHK : S_DONE;
        end
      end
      S_FREE_CHK: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    fresh_d      = fresh_q;
    idx_d        = idx_q;
    has_addr_d   = has_addr_q;
    st_d         = st_q;
    mul_d        = mul_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_st_d     = out_st_q;
    out_addr_d   = out_addr_q;
    dec_start_o  = 1'b0;
    link_we_o    = 1'b0;
    link_waddr_o = idx_q;
    link_wdata_o = nonempty_q ? head_q : idx_q;
    mark_we_o    = 1'b0;
    mark_waddr_o = idx_q;
    mark_wdata_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        st_d       = ST_OK;
        has_addr_d = 1'b0;
        if (accept) begin
          case (op)
            OP_INIT: begin
              head_d     = '0;
              nonempty_d = 1'b0;
              fresh_d    = '0;
            end
            OP_FREE: dec_start_o = 1'b1;
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        if (nonempty_q) begin
          idx_d        = head_q;
          has_addr_d   = 1'b1;
          mark_we_o    = 1'b1;
          mark_waddr_o = head_q;
          mark_wdata_o = 1'b1;
          if ((link_rdata_i == head_q) || (32'(link_rdata_i) >= 32'(MAX_UNITS))) begin
            nonempty_d = 1'b0;
          end else begin
            head_d = link_rdata_i;
          end
        end else if (fresh_q < limit_i) begin
          idx_d        = IDX_W'(fresh_q);
          fresh_d      = fresh_q + 1'b1;
          has_addr_d   = 1'b1;
          mark_we_o    = 1'b1;
          mark_waddr_o = IDX_W'(fresh_q);
          mark_wdata_o = 1'b1;
        end else begin
          st_d = ST_EMPTY;
        end
      end
      S_MUL: mul_d = ADDR_W'(32'(idx_q) * 32'(UNIT_BYTES));
      S_FREE_WAIT: begin
        idx_d = dec_idx_i;
        if (dec_i.done && !dec_i.ok) begin
          st_d = ST_INVALID;
        end
      end
      S_FREE_CHK: begin
        if (mark_rdata_i && (CNT_W'(idx_q) < fresh_q)) begin
          link_we_o  = 1'b1;
          mark_we_o  = 1'b1;
          head_d     = idx_q;
          nonempty_d = 1'b1;
        end else begin
          st_d = ST_INVALID;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_addr_d  = has_addr_q ? (pool_base_i + mul_q) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      fresh_q     <= '0;
      has_addr_q  <= 1'b0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      fresh_q     <= fresh_d;
      has_addr_q  <= has_addr_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    mul_q      <= mul_d;
    out_st_q   <= out_st_d;
    out_addr_q <= out_addr_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_addr_o   = out_addr_q;
  assign link_raddr_o = head_q;
  assign mark_raddr_o = dec_idx_i;

endmodule

// ----- sv/fbpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker
  import fbpa_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [TDATA_W-1:0] s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK) || (m_axis_tdata[1:0] == ST_EMPTY)
                      || (m_axis_tdata[1:0] == ST_INVALID))
    else $error("unknown status code");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[33:2] == '0))
    else $error("unit address set on failed operation");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in back-to-back cycles");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
